/* rtl/core/c2s_pkg.sv */
package c2s_pkg;

   localparam int FRAC_BITS = 24;
   localparam int PA_WIDTH = 34;
   localparam logic [31:0] KGAIN_Q30 = 32'd1768195363;
   localparam logic [31:0] AZ_HALF_TURN = 32'h8000_0000;
   localparam logic [31:0] PA_START = 32'h4000_0000;
   localparam logic [31:0] PA_MAX = 32'h8000_0000;

   localparam logic [15:0] ANGLE_ZERO = 16'd0;
   localparam logic [15:0] ANGLE_QUARTER = 16'd16384;
   localparam logic [15:0] ANGLE_HALF = 16'd32768;
   localparam logic [15:0] ANGLE_THREE_QUARTER = 16'd49152;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic x_zero;
      logic y_zero;
      logic x_neg;
      logic y_neg;
      logic z_neg;
      logic n_zero;
   } flags_type;

   function automatic logic [31:0] c2s_atan(input logic [4:0] idx);
      return ATAN_TAB[idx];
   endfunction

endpackage

/* rtl/core/c2s_ifs.sv */
interface c2s_req_if #(parameter int COORD_WIDTH = 16);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;
   logic signed [COORD_WIDTH-1:0] z_coord;
   modport source(output valid, x_coord, y_coord, z_coord, input ready);
   modport sink(input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface c2s_rsp_if #(parameter int COORD_WIDTH = 16);
   logic valid;
   logic ready;
   logic [COORD_WIDTH-1:0] radius;
   logic [15:0] polar_angle;
   logic [15:0] azimuth;
   modport source(output valid, radius, polar_angle, azimuth, input ready);
   modport sink(input valid, radius, polar_angle, azimuth, output ready);
endinterface

/* rtl/core/c2s_prep.sv */
module c2s_prep
   import c2s_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int DW = COORD_WIDTH + 28,
   parameter int NW = 2 * COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [COORD_WIDTH-1:0] x_in_data,
   input  logic signed [COORD_WIDTH-1:0] y_in_data,
   input  logic signed [COORD_WIDTH-1:0] z_in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic [NW-1:0] n_out,
   output logic signed [DW-1:0] cx_out,
   output logic signed [DW-1:0] cy_out,
   output logic [31:0] az_out,
   output logic signed [DW-1:0] py_out,
   output flags_type flags_out
);

   localparam int PW = COORD_WIDTH + 32;

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   logic signed [COORD_WIDTH-1:0] x1_ff, y1_ff, z1_ff;
   logic signed [COORD_WIDTH-1:0] x2_ff, y2_ff, z2_ff;
   logic signed [NW-1:0] xx_in, yy_in, zz_in;
   logic signed [NW-1:0] xx_ff, yy_ff, zz_ff;
   logic signed [PW-1:0] zk_in, zk_ff;

   logic [NW-1:0] n_in, n_ff;
   logic signed [DW-1:0] cx_in, cy_in, py_in, cx_ff, cy_ff, py_ff;
   logic signed [DW-1:0] xs, ys;
   logic [31:0] az_in, az_ff;
   flags_type flags_in, flags_ff;

   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;
   assign out_valid = v3_ff;

   always_comb begin
      xx_in = NW'(x1_ff) * NW'(x1_ff);
      yy_in = NW'(y1_ff) * NW'(y1_ff);
      zz_in = NW'(z1_ff) * NW'(z1_ff);
      zk_in = PW'(z1_ff) * $signed({{(PW-32){1'b0}}, KGAIN_Q30});
   end

   always_comb begin
      n_in = NW'(xx_ff) + NW'(yy_ff) + NW'(zz_ff);
      xs = DW'(x2_ff) <<< FRAC_BITS;
      ys = DW'(y2_ff) <<< FRAC_BITS;
      if (x2_ff[COORD_WIDTH-1]) begin
         cx_in = -xs;
         cy_in = -ys;
         az_in = AZ_HALF_TURN;
      end else begin
         cx_in = xs;
         cy_in = ys;
         az_in = '0;
      end
      py_in = -DW'(zk_ff >>> (30 - FRAC_BITS));
      flags_in.x_zero = (x2_ff == '0);
      flags_in.y_zero = (y2_ff == '0);
      flags_in.x_neg = x2_ff[COORD_WIDTH-1];
      flags_in.y_neg = y2_ff[COORD_WIDTH-1];
      flags_in.z_neg = z2_ff[COORD_WIDTH-1];
      flags_in.n_zero = (n_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         x1_ff <= x_in_data;
         y1_ff <= y_in_data;
         z1_ff <= z_in_data;
      end
      if (en2) begin
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         zz_ff <= zz_in;
         zk_ff <= zk_in;
      end
      if (en3) begin
         n_ff <= n_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         az_ff <= az_in;
         py_ff <= py_in;
         flags_ff <= flags_in;
      end
   end

   assign n_out = n_ff;
   assign cx_out = cx_ff;
   assign cy_out = cy_ff;
   assign az_out = az_ff;
   assign py_out = py_ff;
   assign flags_out = flags_ff;

endmodule

/* rtl/core/c2s_cordic.sv */
module c2s_cordic
   import c2s_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int CORDIC_STAGES = 16,
   parameter int DW = COORD_WIDTH + 28,
   parameter int NW = 2 * COORD_WIDTH,
   parameter int DEPTH = (2 * CORDIC_STAGES > COORD_WIDTH) ? 2 * CORDIC_STAGES : COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [NW-1:0] n_in_data,
   input  logic signed [DW-1:0] cx_in_data,
   input  logic signed [DW-1:0] cy_in_data,
   input  logic [31:0] az_in_data,
   input  logic signed [DW-1:0] py_in_data,
   input  flags_type flags_in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic [31:0] az_out,
   output logic signed [PA_WIDTH-1:0] pa_out,
   output logic [NW-1:0] rem_out,
   output logic [NW-1:0] root_out,
   output flags_type flags_out
);

   typedef struct packed {
      logic signed [DW-1:0] cx;
      logic signed [DW-1:0] cy;
      logic signed [DW-1:0] px;
      logic signed [DW-1:0] py;
      logic [31:0] az;
      logic signed [PA_WIDTH-1:0] pa;
      logic [NW-1:0] rem;
      logic [NW-1:0] root;
      flags_type flags;
   } pt_type;

   function automatic pt_type step(input pt_type a, input int idx);
      pt_type r;
      logic signed [DW-1:0] tx, ty;
      logic [NW:0] trial;
      logic [NW-1:0] bitv;
      logic [31:0] ang;
      int s;
      r = a;
      if (idx < CORDIC_STAGES) begin
         s = idx;
         ang = c2s_atan(5'(s));
         if (!a.cy[DW-1]) begin
            r.cx = a.cx + (a.cy >>> s);
            r.cy = a.cy - (a.cx >>> s);
            r.az = a.az + ang;
         end else begin
            r.cx = a.cx - (a.cy >>> s);
            r.cy = a.cy + (a.cx >>> s);
            r.az = a.az - ang;
         end
      end else if (idx < 2 * CORDIC_STAGES) begin
         s = idx - CORDIC_STAGES;
         ang = c2s_atan(5'(s));
         tx = (idx == CORDIC_STAGES) ? a.cx : a.px;
         ty = a.py;
         if (!ty[DW-1]) begin
            r.px = tx + (ty >>> s);
            r.py = ty - (tx >>> s);
            r.pa = a.pa + $signed({{(PA_WIDTH-32){1'b0}}, ang});
         end else begin
            r.px = tx - (ty >>> s);
            r.py = ty + (tx >>> s);
            r.pa = a.pa - $signed({{(PA_WIDTH-32){1'b0}}, ang});
         end
      end
      if (idx < COORD_WIDTH) begin
         bitv = NW'(1) << (2 * (COORD_WIDTH - 1 - idx));
         trial = {1'b0, a.root} + {1'b0, bitv};
         if ({1'b0, a.rem} >= trial) begin
            r.rem = a.rem - trial[NW-1:0];
            r.root = (a.root >> 1) + bitv;
         end else begin
            r.root = a.root >> 1;
         end
      end
      return r;
   endfunction

   pt_type head;
   pt_type st_ff [1:DEPTH];
   pt_type st_in [1:DEPTH];
   logic v_ff [1:DEPTH];
   logic en [1:DEPTH];

   always_comb begin
      head.cx = cx_in_data;
      head.cy = cy_in_data;
      head.px = '0;
      head.py = py_in_data;
      head.az = az_in_data;
      head.pa = $signed({{(PA_WIDTH-32){1'b0}}, PA_START});
      head.rem = n_in_data;
      head.root = '0;
      head.flags = flags_in_data;
   end

   for (genvar k = 1; k <= DEPTH; k++) begin : g_stage
      if (k == 1) begin : g_first
         assign st_in[k] = step(head, k - 1);
         assign en[k] = !v_ff[k] || ((k == DEPTH) ? out_ready : en[k+1]);
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= in_valid;
            end
         end
      end else begin : g_rest
         assign st_in[k] = step(st_ff[k-1], k - 1);
         if (k == DEPTH) begin : g_last
            assign en[k] = !v_ff[k] || out_ready;
         end else begin : g_mid
            assign en[k] = !v_ff[k] || en[k+1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en[k]) st_ff[k] <= st_in[k];
      end
   end

   assign in_ready = en[1];
   assign out_valid = v_ff[DEPTH];
   assign az_out = st_ff[DEPTH].az;
   assign pa_out = st_ff[DEPTH].pa;
   assign rem_out = st_ff[DEPTH].rem;
   assign root_out = st_ff[DEPTH].root;
   assign flags_out = st_ff[DEPTH].flags;

endmodule

/* rtl/core/c2s_final.sv */
module c2s_final
   import c2s_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int NW = 2 * COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [31:0] az_in_data,
   input  logic signed [PA_WIDTH-1:0] pa_in_data,
   input  logic [NW-1:0] rem_in_data,
   input  logic [NW-1:0] root_in_data,
   input  flags_type flags_in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic [COORD_WIDTH-1:0] radius_out,
   output logic [15:0] polar_out,
   output logic [15:0] azimuth_out
);

   logic v_ff, en;
   logic [NW-1:0] root_rnd;
   logic [31:0] pa_clamp;
   logic [COORD_WIDTH-1:0] radius_in, radius_ff;
   logic [15:0] polar_in, polar_ff, azimuth_in, azimuth_ff;
   flags_type f;

   assign en = !v_ff || out_ready;
   assign in_ready = en;
   assign out_valid = v_ff;

   always_comb begin
      f = flags_in_data;
      root_rnd = (rem_in_data > root_in_data) ? root_in_data + NW'(1) : root_in_data;
      radius_in = root_rnd[COORD_WIDTH-1:0];

      priority if (f.y_zero && !f.x_zero && !f.x_neg) azimuth_in = ANGLE_ZERO;
      else if (f.x_zero && !f.y_zero && !f.y_neg) azimuth_in = ANGLE_QUARTER;
      else if (f.y_zero && f.x_neg) azimuth_in = ANGLE_HALF;
      else if (f.x_zero && f.y_neg) azimuth_in = ANGLE_THREE_QUARTER;
      else if (f.x_zero && f.y_zero) azimuth_in = ANGLE_ZERO;
      else azimuth_in = az_in_data[31:16] + 16'(az_in_data[15]);

      priority if (pa_in_data[PA_WIDTH-1]) pa_clamp = '0;
      else if (pa_in_data > $signed({{(PA_WIDTH-32){1'b0}}, PA_MAX})) pa_clamp = PA_MAX;
      else pa_clamp = pa_in_data[31:0];

      if (f.x_zero && f.y_zero) begin
         polar_in = f.z_neg ? ANGLE_HALF : ANGLE_ZERO;
      end else begin
         polar_in = pa_clamp[31:16] + 16'(pa_clamp[15]);
      end

      if (f.n_zero) begin
         radius_in = '0;
         polar_in = ANGLE_ZERO;
         azimuth_in = ANGLE_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         radius_ff <= radius_in;
         polar_ff <= polar_in;
         azimuth_ff <= azimuth_in;
      end
   end

   assign radius_out = radius_ff;
   assign polar_out = polar_ff;
   assign azimuth_out = azimuth_ff;

endmodule

/* rtl/core/cartesian_to_spherical.sv */
// Pipeline: three setup stages (input capture, squares and gain multiply, sums), one stage
// per CORDIC step, one output stage. Throughput: one point per cycle when not stalled;
// every stage holds its own item, stalls back up stage by stage and bubbles are filled.
// Square root runs one result bit per stage alongside.
// Reset (synchronous) clears all valid bits; nothing in flight survives it.
module cartesian_to_spherical
   import c2s_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int CORDIC_STAGES = 16
) (
   input logic clock,
   input logic reset,
   c2s_req_if.sink req_ch,
   c2s_rsp_if.source rsp_ch
);

   localparam int DW = COORD_WIDTH + 28;
   localparam int NW = 2 * COORD_WIDTH;

   logic p_valid, p_ready, c_valid, c_ready;
   logic [NW-1:0] p_n;
   logic signed [DW-1:0] p_cx, p_cy, p_py;
   logic [31:0] p_az, c_az;
   flags_type p_flags, c_flags;
   logic signed [PA_WIDTH-1:0] c_pa;
   logic [NW-1:0] c_rem, c_root;

   c2s_prep #(.COORD_WIDTH(COORD_WIDTH), .DW(DW), .NW(NW)) u_prep (
      .clock(clock), .reset(reset),
      .in_valid(req_ch.valid), .in_ready(req_ch.ready),
      .x_in_data(req_ch.x_coord), .y_in_data(req_ch.y_coord), .z_in_data(req_ch.z_coord),
      .out_valid(p_valid), .out_ready(p_ready),
      .n_out(p_n), .cx_out(p_cx), .cy_out(p_cy), .az_out(p_az), .py_out(p_py),
      .flags_out(p_flags)
   );

   c2s_cordic #(
      .COORD_WIDTH(COORD_WIDTH), .CORDIC_STAGES(CORDIC_STAGES), .DW(DW), .NW(NW)
   ) u_cordic (
      .clock(clock), .reset(reset),
      .in_valid(p_valid), .in_ready(p_ready),
      .n_in_data(p_n), .cx_in_data(p_cx), .cy_in_data(p_cy), .az_in_data(p_az),
      .py_in_data(p_py), .flags_in_data(p_flags),
      .out_valid(c_valid), .out_ready(c_ready),
      .az_out(c_az), .pa_out(c_pa), .rem_out(c_rem), .root_out(c_root),
      .flags_out(c_flags)
   );

   c2s_final #(.COORD_WIDTH(COORD_WIDTH), .NW(NW)) u_final (
      .clock(clock), .reset(reset),
      .in_valid(c_valid), .in_ready(c_ready),
      .az_in_data(c_az), .pa_in_data(c_pa), .rem_in_data(c_rem), .root_in_data(c_root),
      .flags_in_data(c_flags),
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready),
      .radius_out(rsp_ch.radius), .polar_out(rsp_ch.polar_angle),
      .azimuth_out(rsp_ch.azimuth)
   );

   a_origin_angles: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.radius == '0 |-> rsp_ch.polar_angle == ANGLE_ZERO
         && rsp_ch.azimuth == ANGLE_ZERO)
      else $error("nonzero angle at origin");

   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.polar_angle <= ANGLE_HALF)
      else $error("polar angle beyond pi");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import c2s_pkg::*;

   typedef struct packed {
      logic [15:0] radius;
      logic [15:0] polar;
      logic [15:0] azimuth;
   } sph_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic fixed;
      sph_type want;
   } point_type;

   localparam int N_RANDOM = 1130;
   localparam int PHASE_LEN = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT_CYCLES = 400000;

   // x, y, z, expected given, radius, polar angle, azimuth
   localparam int N_DIRECTED = 23;
   localparam int DIRECTED [N_DIRECTED][7] = '{
      '{0, 0, 0, 1, 0, int'(ANGLE_ZERO), int'(ANGLE_ZERO)},
      '{0, 0, 100, 1, 100, int'(ANGLE_ZERO), int'(ANGLE_ZERO)},
      '{0, 0, -100, 1, 100, int'(ANGLE_HALF), int'(ANGLE_ZERO)},
      '{0, 0, 32767, 1, 32767, int'(ANGLE_ZERO), int'(ANGLE_ZERO)},
      '{0, 0, -32768, 1, 32768, int'(ANGLE_HALF), int'(ANGLE_ZERO)},
      '{7, 0, 0, 0, 0, 0, 0},
      '{-7, 0, 0, 0, 0, 0, 0},
      '{0, 7, 0, 0, 0, 0, 0},
      '{0, -7, 0, 0, 0, 0, 0},
      '{32767, 0, 0, 0, 0, 0, 0},
      '{-32768, 0, 0, 0, 0, 0, 0},
      '{0, 32767, 0, 0, 0, 0, 0},
      '{0, -32768, 0, 0, 0, 0, 0},
      '{32767, 32767, 32767, 0, 0, 0, 0},
      '{-32768, -32768, -32768, 0, 0, 0, 0},
      '{-32768, 32767, -1, 0, 0, 0, 0},
      '{1, 1, 1, 0, 0, 0, 0},
      '{-1, -1, 1, 0, 0, 0, 0},
      '{3, 4, 0, 0, 0, 0, 0},
      '{1, 0, 1, 0, 0, 0, 0},
      '{0, -1, -1, 0, 0, 0, 0},
      '{12345, -23456, 345, 0, 0, 0, 0},
      '{-1, 1, 0, 0, 0, 0, 0}
   };

   logic clock;
   logic reset;
   int errors = 0;
   int sent = 0;
   int total = 0;
   int cycles = 0;
   point_type stim_q[$];
   sph_type sph_q[$];

   c2s_req_if #(.COORD_WIDTH(16)) req_ch();
   c2s_rsp_if #(.COORD_WIDTH(16)) rsp_ch();

   cartesian_to_spherical #(.COORD_WIDTH(16), .CORDIC_STAGES(16)) u_top (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   function automatic sph_type convert_point(logic signed [15:0] xi, logic signed [15:0] yi,
                                             logic signed [15:0] zi);
      longint x, y, z, n, cx, cy, tx, px, py, pa;
      longint unsigned rem, root, bt;
      logic [31:0] az;
      logic [63:0] t;
      sph_type r;
      x = xi;
      y = yi;
      z = zi;
      n = x * x + y * y + z * z;
      rem = n;
      root = 0;
      bt = 64'd1 << 62;
      while (bt > longint'(n)) bt = bt >> 2;
      while (bt != 0) begin
         if (rem >= root + bt) begin
            rem = rem - (root + bt);
            root = (root >> 1) + bt;
         end else begin
            root = root >> 1;
         end
         bt = bt >> 2;
      end
      if (rem > root) root++;
      r = '0;
      if (n == 0) return r;
      r.radius = root[15:0];

      cx = x * (64'sd1 <<< FRAC_BITS);
      cy = y * (64'sd1 <<< FRAC_BITS);
      az = '0;
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         az = AZ_HALF_TURN;
      end
      for (int i = 0; i < 16; i++) begin
         tx = cx;
         if (cy >= 0) begin
            cx += cy >>> i; cy -= tx >>> i; az += ATAN_TAB[i];
         end else begin
            cx -= cy >>> i; cy += tx >>> i; az -= ATAN_TAB[i];
         end
      end
      t = {32'b0, az} + 64'h8000;
      r.azimuth = t[31:16];
      if (y == 0 && x > 0) r.azimuth = ANGLE_ZERO;
      else if (x == 0 && y > 0) r.azimuth = ANGLE_QUARTER;
      else if (y == 0 && x < 0) r.azimuth = ANGLE_HALF;
      else if (x == 0 && y < 0) r.azimuth = ANGLE_THREE_QUARTER;
      else if (x == 0 && y == 0) r.azimuth = ANGLE_ZERO;

      px = cx;
      py = -((z * longint'(KGAIN_Q30)) >>> (30 - FRAC_BITS));
      pa = longint'(PA_START);
      for (int i = 0; i < 16; i++) begin
         tx = px;
         if (py >= 0) begin
            px += py >>> i; py -= tx >>> i; pa += longint'(ATAN_TAB[i]);
         end else begin
            px -= py >>> i; py += tx >>> i; pa -= longint'(ATAN_TAB[i]);
         end
      end
      if (pa < 0) pa = 0;
      if (pa > longint'(PA_MAX)) pa = longint'(PA_MAX);
      t = pa + 64'h8000;
      r.polar = t[31:16];
      if (x == 0 && y == 0) r.polar = (z < 0) ? ANGLE_HALF : ANGLE_ZERO;
      return r;
   endfunction

   function automatic void add_point(int x, int y, int z, bit fixed = 0,
                                     int rad = 0, int pol = 0, int azi = 0);
      point_type p;
      p.x = 16'(x);
      p.y = 16'(y);
      p.z = 16'(z);
      p.fixed = fixed;
      p.want.radius = 16'(rad);
      p.want.polar = 16'(pol);
      p.want.azimuth = 16'(azi);
      stim_q.push_back(p);
   endfunction

   function automatic int pick_coord(int mode);
      case (mode)
         0: return $signed(16'($urandom));
         1: return $urandom_range(128) - 64;
         2: return 0;
         default: begin
            case ($urandom_range(5))
               0: return -32768;
               1: return 32767;
               2: return -1;
               3: return 0;
               4: return 1;
               default: return $signed(16'($urandom));
            endcase
         end
      endcase
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s at %0d: got %0d, want %0d", what, cycles, got, want);
      errors++;
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout");
         $display("** cartesian_to_spherical: FAILED **");
         $finish;
      end
   end

   // stimulus
   initial begin
      int mode;
      bit hold;
      req_ch.valid = 0;
      req_ch.x_coord = 0;
      req_ch.y_coord = 0;
      req_ch.z_coord = 0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         add_point(DIRECTED[i][0], DIRECTED[i][1], DIRECTED[i][2], DIRECTED[i][3] != 0,
                   DIRECTED[i][4], DIRECTED[i][5], DIRECTED[i][6]);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         mode = $urandom_range(99);
         if (mode < 50) add_point(pick_coord(0), pick_coord(0), pick_coord(0));
         else if (mode < 70) add_point(pick_coord(1), pick_coord(1), pick_coord(1));
         else if (mode < 85)
            add_point(pick_coord($urandom_range(2)), pick_coord($urandom_range(2)),
                      pick_coord($urandom_range(2)));
         else add_point(pick_coord(3), pick_coord(3), pick_coord(3));
      end
      total = stim_q.size();

      @(negedge reset);
      while (sent < total) begin
         @(posedge clock);
         hold = 0;
         if (req_ch.valid && req_ch.ready) begin
            if (stim_q[sent].fixed) sph_q.push_back(stim_q[sent].want);
            else sph_q.push_back(convert_point(stim_q[sent].x, stim_q[sent].y,
                                                stim_q[sent].z));
            sent++;
         end else if (req_ch.valid) begin
            hold = 1;
         end
         if (!hold) begin
            if (sent < total &&
                !(sent < PHASE_LEN && $urandom_range(99) < 21) &&
                !(sent >= PHASE_LEN && sent < 2 * PHASE_LEN && $urandom_range(99) < 87)) begin
               req_ch.valid <= 1;
               req_ch.x_coord <= stim_q[sent].x;
               req_ch.y_coord <= stim_q[sent].y;
               req_ch.z_coord <= stim_q[sent].z;
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
      while (sph_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("** cartesian_to_spherical: PASSED **");
      else $display("** cartesian_to_spherical: FAILED **");
      $finish;
   end

   // receiver backpressure
   initial begin
      bit held;
      held = 0;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && sent >= 2 * PHASE_LEN + 20) begin
            held = 1;
            rsp_ch.ready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (sent < PHASE_LEN) rsp_ch.ready <= ($urandom_range(99) >= 87);
         else if (sent < 2 * PHASE_LEN) rsp_ch.ready <= ($urandom_range(99) >= 21);
         else rsp_ch.ready <= 1;
      end
   end

   // result check
   initial begin
      sph_type exp_r;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (sph_q.size() == 0) begin
               report("unexpected transfer", rsp_ch.radius, 0);
            end else begin
               exp_r = sph_q.pop_front();
               if (rsp_ch.radius !== exp_r.radius)
                  report("radius", rsp_ch.radius, exp_r.radius);
               if (rsp_ch.polar_angle !== exp_r.polar)
                  report("polar_angle", rsp_ch.polar_angle, exp_r.polar);
               if (rsp_ch.azimuth !== exp_r.azimuth)
                  report("azimuth", rsp_ch.azimuth, exp_r.azimuth);
            end
         end
      end
   end

endmodule
